[rtl/cia_pkg.sv]
// Shared widths, codes and stage types of the checked integer ALU.
package cia_pkg;

    localparam int DATA_WIDTH = 64;
    localparam int HALF       = (DATA_WIDTH + 1) / 2;
    localparam int PROD_WIDTH = 2 * DATA_WIDTH;
    localparam int PP_WIDTH   = 2 * HALF;
    localparam int PORT_WIDTH = 64;

    typedef logic [2:0]            action_t;
    typedef logic [1:0]            status_t;
    typedef logic [DATA_WIDTH-1:0] word_t;
    typedef logic [PP_WIDTH-1:0]   pp_t;

    localparam action_t ACT_ADD = 3'd0;
    localparam action_t ACT_SUB = 3'd1;
    localparam action_t ACT_MUL = 3'd2;
    localparam action_t ACT_DIV = 3'd3;
    localparam action_t ACT_REM = 3'd4;

    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_DIV0 = 2'd1;
    localparam status_t ST_OVF  = 2'd2;

    typedef struct packed {
        action_t act;
        logic    neg_a;
        logic    neg_q;
        logic    div0;
        logic    divovf;
        logic    bm1;
        logic    ovf;
        word_t   res;
        word_t   rem;
        word_t   quo;
        word_t   bmag;
    } pipe_t;

    typedef struct packed {
        pipe_t base;
        logic  mneg;
        pp_t   pp_ll;
        pp_t   pp_lh;
        pp_t   pp_hl;
        pp_t   pp_hh;
    } front_t;

endpackage

[rtl/cia_in_if.sv]
// Request channel: operation and two signed operands.
interface cia_in_if;
    import cia_pkg::*;
    logic                         valid;
    logic                         ready;
    logic [2:0]                   action;
    logic signed [PORT_WIDTH-1:0] left;
    logic signed [PORT_WIDTH-1:0] right;
    modport source (output valid, output action, output left, output right, input ready);
    modport sink   (input valid, input action, input left, input right, output ready);
endinterface

[rtl/cia_out_if.sv]
// Response channel: signed value and status.
interface cia_out_if;
    import cia_pkg::*;
    logic                         valid;
    logic                         ready;
    logic signed [PORT_WIDTH-1:0] value;
    logic [1:0]                   status;
    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

[rtl/cia_front.sv]
// Operand decode, add/subtract with overflow, multiplier partial products.
module cia_front
    import cia_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  vin,
    input  action_t               action,
    input  logic [PORT_WIDTH-1:0] left,
    input  logic [PORT_WIDTH-1:0] right,
    output logic                  valid_reg,
    output front_t                data_reg
);

    localparam word_t MIN_W = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    word_t                       a, b, amag, bmag;
    logic [DATA_WIDTH:0]         sum, dif;
    logic [HALF-1:0]             al, ah, bl, bh;
    front_t                      data_next;

    always_comb
    begin
        a    = left[DATA_WIDTH-1:0];
        b    = right[DATA_WIDTH-1:0];
        amag = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
        bmag = b[DATA_WIDTH-1] ? (~b + 1'b1) : b;
        sum  = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
        dif  = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
        al   = amag[HALF-1:0];
        bl   = bmag[HALF-1:0];
        ah   = HALF'(amag >> HALF);
        bh   = HALF'(bmag >> HALF);

        data_next             = '0;
        data_next.base.act    = action;
        data_next.base.neg_a  = a[DATA_WIDTH-1];
        data_next.base.neg_q  = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
        data_next.base.div0   = (b == '0);
        data_next.base.bm1    = (b == '1);
        data_next.base.divovf = (a == MIN_W) && (b == '1);
        data_next.base.rem    = '0;
        data_next.base.quo    = amag;
        data_next.base.bmag   = bmag;
        data_next.mneg        = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
        data_next.pp_ll       = al * bl;
        data_next.pp_lh       = al * bh;
        data_next.pp_hl       = ah * bl;
        data_next.pp_hh       = ah * bh;
        unique case (action)
            ACT_ADD:
            begin
                data_next.base.res = sum[DATA_WIDTH-1:0];
                data_next.base.ovf = sum[DATA_WIDTH] ^ sum[DATA_WIDTH-1];
            end
            ACT_SUB:
            begin
                data_next.base.res = dif[DATA_WIDTH-1:0];
                data_next.base.ovf = dif[DATA_WIDTH] ^ dif[DATA_WIDTH-1];
            end
            default:
            begin
                data_next.base.res = '0;
                data_next.base.ovf = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= vin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

endmodule

[rtl/cia_mulsum.sv]
// Partial product sum, multiply range check and sign.
module cia_mulsum
    import cia_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   vin,
    input  front_t din,
    output logic   valid_reg,
    output pipe_t  data_reg
);

    localparam logic [PROD_WIDTH-1:0] LIM_POS =
        (PROD_WIDTH'(1) << (DATA_WIDTH - 1)) - PROD_WIDTH'(1);

    logic [PROD_WIDTH-1:0] prod, limit;
    word_t                 plow;
    pipe_t                 data_next;

    always_comb
    begin
        prod = PROD_WIDTH'(din.pp_ll)
             + (PROD_WIDTH'(din.pp_lh) << HALF)
             + (PROD_WIDTH'(din.pp_hl) << HALF)
             + (PROD_WIDTH'(din.pp_hh) << (2 * HALF));
        limit     = din.mneg ? (LIM_POS + PROD_WIDTH'(1)) : LIM_POS;
        plow      = prod[DATA_WIDTH-1:0];
        data_next = din.base;
        if (din.base.act == ACT_MUL)
        begin
            data_next.ovf = (prod > limit);
            data_next.res = (prod > limit) ? '0 : (din.mneg ? (~plow + 1'b1) : plow);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= vin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

endmodule

[rtl/cia_div_step.sv]
// One restoring division step: one quotient bit per stage.
module cia_div_step
    import cia_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  vin,
    input  pipe_t din,
    output logic  valid_reg,
    output pipe_t data_reg
);

    logic [DATA_WIDTH:0] r2, diff;
    pipe_t               data_next;

    always_comb
    begin
        r2        = {din.rem, din.quo[DATA_WIDTH-1]};
        diff      = r2 - {1'b0, din.bmag};
        data_next = din;
        data_next.quo = {din.quo[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
        data_next.rem = diff[DATA_WIDTH] ? r2[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= vin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

endmodule

[rtl/cia_back.sv]
// Result select, status and output register.
module cia_back
    import cia_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  vin,
    input  pipe_t                 din,
    output logic                  valid_reg,
    output logic [PORT_WIDTH-1:0] value_reg,
    output status_t               status_reg
);

    word_t   val;
    status_t st;

    always_comb
    begin
        val = '0;
        st  = ST_OK;
        unique case (din.act)
            ACT_ADD, ACT_SUB, ACT_MUL:
            begin
                st  = din.ovf ? ST_OVF : ST_OK;
                val = din.ovf ? '0 : din.res;
            end
            ACT_DIV:
            begin
                priority if (din.div0)
                    st = ST_DIV0;
                else if (din.divovf)
                    st = ST_OVF;
                else
                    val = din.neg_q ? (~din.quo + 1'b1) : din.quo;
            end
            ACT_REM:
            begin
                priority if (din.div0)
                    st = ST_DIV0;
                else if (din.bm1)
                    val = '0;
                else
                    val = din.neg_a ? (~din.rem + 1'b1) : din.rem;
            end
            default:
            begin
                val = '0;
                st  = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= vin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg  <= PORT_WIDTH'(signed'(val));
            status_reg <= st;
        end
    end

endmodule

[rtl/checked_int64_alu_core.sv]
// Top level of the overflow-checked signed integer ALU.
// One beat in gives one beat out, in order. Add, subtract, multiply, truncating
// divide and remainder run through one pipeline of DATA_WIDTH + 3 register stages
// (operand decode, partial product sum, one stage per quotient bit of the
// restoring divider, result select), and a new request is taken in every
// cycle while the output is not stalled. Status is 0 ok, 1 division by zero,
// 2 overflow; value is zero whenever status is not ok. The pipeline holds while
// a result waits on the output and ready is low.
module checked_int64_alu_core
    import cia_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    cia_in_if.sink     req,
    cia_out_if.source  rsp
);

    logic   en;
    logic   front_valid, mul_valid, back_valid;
    front_t front_data;
    pipe_t  mul_data;
    logic   step_valid [DATA_WIDTH+1];
    pipe_t  step_data  [DATA_WIDTH+1];
    logic [PORT_WIDTH-1:0] value_reg;
    status_t               status_reg;

    assign en        = !back_valid || rsp.ready;
    assign req.ready = en;

    cia_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .vin       (req.valid),
        .action    (req.action),
        .left      (req.left),
        .right     (req.right),
        .valid_reg (front_valid),
        .data_reg  (front_data)
    );

    cia_mulsum u_mulsum (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .vin       (front_valid),
        .din       (front_data),
        .valid_reg (mul_valid),
        .data_reg  (mul_data)
    );

    assign step_valid[0] = mul_valid;
    assign step_data[0]  = mul_data;

    for (genvar i = 0; i < DATA_WIDTH; i++)
    begin : g_div
        cia_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .vin       (step_valid[i]),
            .din       (step_data[i]),
            .valid_reg (step_valid[i+1]),
            .data_reg  (step_data[i+1])
        );
    end

    cia_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .vin        (step_valid[DATA_WIDTH]),
        .din        (step_data[DATA_WIDTH]),
        .valid_reg  (back_valid),
        .value_reg  (value_reg),
        .status_reg (status_reg)
    );

    assign rsp.valid  = back_valid;
    assign rsp.value  = value_reg;
    assign rsp.status = status_reg;

    a_null_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status != ST_OK) |-> (rsp.value == '0))
        else $error("nonzero value with error status");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.status == ST_OK || rsp.status == ST_DIV0 || rsp.status == ST_OVF))
        else $error("undefined status code");

    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> $stable(step_valid[DATA_WIDTH]) && $stable(mul_valid))
        else $error("pipeline moved during output stall");

endmodule
